// ===== hw/rtl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  // fixed field widths of the channels
  localparam int unsigned OP_BITS  = 3;
  localparam int unsigned A_BITS   = 62;
  localparam int unsigned B_BITS   = 63;
  localparam int unsigned RES_BITS = 62;
  localparam int unsigned CFG_BITS = 62;

  // default modulus size and reset value of the modulus
  localparam int unsigned MOD_BITS_DEF = 62;
  localparam logic [CFG_BITS-1:0] MOD_RESET = CFG_BITS'(64'd998244353);

  // opcodes
  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_POW = 3'd4,
    OP_INV = 3'd5,
    OP_DIV = 3'd6
  } op_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_EXEC,
    S_MUL,
    S_POW_CHK,
    S_POW_ACC,
    S_POW_SQR,
    S_INV_CHK,
    S_INV_DIV,
    S_INV_QRED,
    S_INV_MUL,
    S_DIV_MUL,
    S_DONE
  } state_e;

endpackage

// ===== hw/rtl/mau_req_if.sv =====
// ----------------------------------------------------------------------------
// mau_req_if
// Request channel: opcode and two operands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mau_req_if
  import mau_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  op;
  logic [A_BITS-1:0]   first_operand;
  logic [B_BITS-1:0]   second_operand;

  modport source (output valid, output op, output first_operand,
                  output second_operand, input ready);
  modport sink   (input valid, input op, input first_operand,
                  input second_operand, output ready);
endinterface

// ===== hw/rtl/mau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mau_rsp_if
// Response channel: one result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mau_rsp_if
  import mau_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RES_BITS-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== hw/rtl/mau_mulmod.sv =====
// ----------------------------------------------------------------------------
// mau_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, lsb first,
// with the addend doubled modulo m alongside the conditional accumulate.
// ----------------------------------------------------------------------------
module mau_mulmod
  import mau_pkg::*;
#(
  parameter int unsigned W = MOD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  addend_q, addend_d;
  logic [W-1:0]  mult_q, mult_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          go;

  function automatic logic [W-1:0] add_m(logic [W-1:0] a, logic [W-1:0] b,
                                         logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  assign go = start_i && !busy_q && !done_q;

  // one multiplier bit per cycle
  always_comb begin
    acc_d    = acc_q;
    addend_d = addend_q;
    mult_d   = mult_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (go) begin
      acc_d    = '0;
      addend_d = x_i;
      mult_d   = y_i;
      cnt_d    = CW'(W);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mult_q[0]) begin
        acc_d = add_m(acc_q, addend_q, m_i);
      end
      addend_d = add_m(addend_q, addend_q, m_i);
      mult_d   = mult_q >> 1;
      cnt_d    = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    addend_q <= addend_d;
    mult_q   <= mult_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular ALU: add, sub, negate, multiply, power, inverse and divide.
// ----------------------------------------------------------------------------
// One request is worked at a time; a new one is taken once the previous
// result sits in the output register. Every request with a modulus of two
// or more first reduces both operands bit by bit. Add, sub and negate are
// then computed in the execute state. Multiply runs on the shared bit-serial
// multiplier. Power costs one multiply per exponent bit plus one more per set
// bit. Inverse runs the extended Euclidean loop; each round is a serial
// divide and a serial multiply. Divide is an inverse followed by a multiply.
// With a modulus below two the answer is zero and the operands are not
// reduced.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  mau_req_if.sink             req_i,
  mau_rsp_if.source           rsp_o
);

  localparam int unsigned W  = MOD_BITS;
  localparam int unsigned RW = $clog2(B_BITS + 1);
  localparam int unsigned DW = $clog2(W + 1);

  state_e state_q, state_d;

  logic [CFG_BITS-1:0] modulus_q;
  logic [W-1:0]        m;

  op_e              op_q;
  logic [B_BITS-1:0] sh_q;
  logic [B_BITS-1:0] exp_q;
  logic [W-1:0]     rem_q;
  logic [RW-1:0]    rcnt_q;
  logic [W-1:0]     ra_q, rb_q;
  logic [W-1:0]     pacc_q, pbase_q;
  logic [W-1:0]     ea_q, eb_q, eu_q, ev_q;
  logic [W-1:0]     dnum_q, dq_q;
  logic [W:0]       drem_q;
  logic [DW-1:0]    dcnt_q;
  logic [W-1:0]     res_q;
  logic             out_valid_q;
  logic [W-1:0]     out_data_q;

  logic             mul_start, mul_done;
  logic [W-1:0]     mul_x, mul_y, mul_p;
  logic             out_load;

  logic [W:0]       red_next;
  logic [W:0]       div_next;
  logic             div_bit;

  function automatic logic [W-1:0] add_m(logic [W-1:0] a, logic [W-1:0] b,
                                         logic [W-1:0] mm);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, mm}) begin
      s = s - {1'b0, mm};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_m(logic [W-1:0] a, logic [W-1:0] b,
                                         logic [W-1:0] mm);
    logic [W-1:0] d;
    d = a - b;
    if (a < b) begin
      d = d + mm;
    end
    return d;
  endfunction

  assign m = modulus_q[W-1:0];

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // shared serial multiplier
  mau_mulmod #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .m_i     (m),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  // reduction step: shift in one bit, subtract once
  always_comb begin
    red_next = {rem_q, sh_q[B_BITS-1]};
    if (red_next >= {1'b0, m}) begin
      red_next = red_next - {1'b0, m};
    end
  end

  // restoring division step
  always_comb begin
    div_next = {drem_q[W-1:0], dnum_q[W-1]};
    div_bit  = 1'b0;
    if (div_next >= {1'b0, eb_q}) begin
      div_next = div_next - {1'b0, eb_q};
      div_bit  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = (m < W'(2)) ? S_DONE : S_RED_A;
        end
      end
      S_RED_A: if (rcnt_q == RW'(1)) state_d = S_RED_B;
      S_RED_B: if (rcnt_q == RW'(1)) state_d = S_EXEC;
      S_EXEC: begin
        case (op_q)
          OP_MUL:          state_d = S_MUL;
          OP_POW:          state_d = S_POW_CHK;
          OP_INV, OP_DIV:  state_d = S_INV_CHK;
          default:         state_d = S_DONE;
        endcase
      end
      S_MUL:     if (mul_done) state_d = S_DONE;
      S_POW_CHK: begin
        if (exp_q == '0) begin
          state_d = S_DONE;
        end else if (exp_q[0]) begin
          state_d = S_POW_ACC;
        end else begin
          state_d = S_POW_SQR;
        end
      end
      S_POW_ACC: if (mul_done) state_d = S_POW_SQR;
      S_POW_SQR: if (mul_done) state_d = S_POW_CHK;
      S_INV_CHK: begin
        if (eb_q == '0) begin
          state_d = (op_q == OP_DIV) ? S_DIV_MUL : S_DONE;
        end else begin
          state_d = S_INV_DIV;
        end
      end
      S_INV_DIV:  if (dcnt_q == DW'(1)) state_d = S_INV_QRED;
      S_INV_QRED: state_d = S_INV_MUL;
      S_INV_MUL:  if (mul_done) state_d = S_INV_CHK;
      S_DIV_MUL:  if (mul_done) state_d = S_DONE;
      S_DONE:     if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_start = 1'b0;
    mul_x     = ra_q;
    mul_y     = rb_q;
    case (state_q)
      S_MUL: begin
        mul_start = !mul_done;
      end
      S_POW_ACC: begin
        mul_start = !mul_done;
        mul_x     = pacc_q;
        mul_y     = pbase_q;
      end
      S_POW_SQR: begin
        mul_start = !mul_done;
        mul_x     = pbase_q;
        mul_y     = pbase_q;
      end
      S_INV_MUL: begin
        mul_start = !mul_done;
        mul_x     = dq_q;
        mul_y     = ev_q;
      end
      S_DIV_MUL: begin
        mul_start = !mul_done;
        mul_x     = ra_q;
        mul_y     = eu_q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rcnt_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:    rcnt_q <= RW'(A_BITS);
        S_RED_A:   rcnt_q <= (rcnt_q == RW'(1)) ? RW'(B_BITS) : rcnt_q - RW'(1);
        S_RED_B:   rcnt_q <= rcnt_q - RW'(1);
        S_INV_CHK: dcnt_q <= DW'(W);
        S_INV_DIV: dcnt_q <= dcnt_q - DW'(1);
        default:   rcnt_q <= rcnt_q;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
    end
    case (state_q)
      S_IDLE: begin
        op_q  <= op_e'(req_i.op);
        sh_q  <= {req_i.first_operand, 1'b0};
        exp_q <= req_i.second_operand;
        rem_q <= '0;
        res_q <= '0;
      end
      S_RED_A: begin
        if (rcnt_q == RW'(1)) begin
          ra_q  <= red_next[W-1:0];
          rem_q <= '0;
          sh_q  <= exp_q;
        end else begin
          rem_q <= red_next[W-1:0];
          sh_q  <= sh_q << 1;
        end
      end
      S_RED_B: begin
        rem_q <= red_next[W-1:0];
        sh_q  <= sh_q << 1;
        if (rcnt_q == RW'(1)) begin
          rb_q <= red_next[W-1:0];
        end
      end
      S_EXEC: begin
        pacc_q  <= W'(1);
        pbase_q <= ra_q;
        ea_q    <= (op_q == OP_DIV) ? rb_q : ra_q;
        eb_q    <= m;
        eu_q    <= W'(1);
        ev_q    <= '0;
        case (op_q)
          OP_ADD:  res_q <= add_m(ra_q, rb_q, m);
          OP_SUB:  res_q <= sub_m(ra_q, rb_q, m);
          OP_NEG:  res_q <= sub_m('0, ra_q, m);
          default: res_q <= '0;
        endcase
      end
      S_MUL: if (mul_done) res_q <= mul_p;
      S_POW_CHK: if (exp_q == '0) res_q <= pacc_q;
      S_POW_ACC: if (mul_done) pacc_q <= mul_p;
      S_POW_SQR: begin
        if (mul_done) begin
          pbase_q <= mul_p;
          exp_q   <= exp_q >> 1;
        end
      end
      S_INV_CHK: begin
        res_q  <= eu_q;
        dnum_q <= ea_q;
        drem_q <= '0;
        dq_q   <= '0;
      end
      S_INV_DIV: begin
        drem_q <= div_next;
        dnum_q <= dnum_q << 1;
        dq_q   <= {dq_q[W-2:0], div_bit};
      end
      S_INV_QRED: if (dq_q >= m) dq_q <= dq_q - m;
      S_INV_MUL: begin
        if (mul_done) begin
          ea_q <= eb_q;
          eb_q <= drem_q[W-1:0];
          eu_q <= ev_q;
          ev_q <= sub_m(eu_q, mul_p, m);
        end
      end
      S_DIV_MUL: if (mul_done) res_q <= mul_p;
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = RES_BITS'(out_data_q);

endmodule
